>>> sv/assert_macros.svh
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled during reset
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled during reset
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> sv/hma_pkg.sv
// shared types and codes of the monitor lock manager
`default_nettype none

package hma_pkg;

    // request kinds
    typedef enum logic [1:0] {
        OP_ENTER  = 2'd0,
        OP_LEAVE  = 2'd1,
        OP_WAIT   = 2'd2,
        OP_SIGNAL = 2'd3
    } t_op;

    // result status codes
    typedef enum logic [1:0] {
        ST_RELEASE = 2'd0,
        ST_BADCOND = 2'd1,
        ST_FULL    = 2'd2
    } t_status;

    // which queue a push or pop goes to
    typedef enum logic [1:0] {
        Q_ENTRY  = 2'd0,
        Q_URGENT = 2'd1,
        Q_COND   = 2'd2
    } t_qsel;

    // where a result's thread comes from
    typedef enum logic [1:0] {
        E_TID  = 2'd0,
        E_ZERO = 2'd1,
        E_MEM  = 2'd2
    } t_esrc;

    localparam logic [3:0] NUM_COND_RESET = 4'd10;

    // request payload
    typedef struct packed {
        logic [1:0] op;
        logic [7:0] thread_id;
        logic [3:0] cond_index;
    } t_req;

    // result payload
    typedef struct packed {
        logic [7:0] released_thread;
        logic [1:0] status;
        logic       last;
    } t_rslt;

    // controller to datapath
    typedef struct packed {
        logic    latch;
        logic    push;
        t_qsel   push_q;
        logic    pop;
        t_qsel   pop_q;
        logic    busy_set;
        logic    busy_clr;
        logic    emit;
        t_esrc   emit_src;
        t_status emit_status;
        logic    emit_last;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        t_op  op;
        logic bad_cond;
        logic busy;
        logic entry_empty;
        logic entry_full;
        logic urgent_empty;
        logic urgent_full;
        logic cond_empty;
        logic cond_full;
        logic out_free;
    } t_stat;

endpackage

`default_nettype wire

>>> sv/hoare_monitor_arbiter.sv
// top level of the monitor lock manager
//
// Requests arrive on the in channel (i_in_valid / o_in_ready, payload
// i_in_data: op, thread_id, cond_index). Each release goes out on the out
// channel (o_out_valid / i_out_ready, payload o_out_data: released_thread,
// status, last); a request gives zero, one or two results, the final one
// marked by last. The cfg channel writes num_conditions; o_cfg_ready is
// always high and writes belong to times when no request is in flight.
// The sequencer latches a request in idle, decides it in the exec state,
// where it may load a result, and goes on to a pop state when a thread is
// popped from a queue, because the queue store has one registered read
// port; the pop state emits the popped thread as the final result. The
// next request is taken only when the sequencer is back in idle.
// A stalled receiver holds the single result register; the sequencer waits
// on it before it commits any queue or ownership change.
// Reset (synchronous, active low) frees the monitor, empties all queues by
// clearing head and count pointers and sets num_conditions to 10; no
// clearing pass runs over the queue store.
`default_nettype none

module hoare_monitor_arbiter #(
    parameter int NUM_CONDS      = 10,
    parameter int QUEUE_DEPTH    = 16,
    parameter int THREAD_ID_BITS = 8
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_in_valid,
    output logic                o_in_ready,
    input  wire hma_pkg::t_req  i_in_data,
    output logic                o_out_valid,
    input  wire logic           i_out_ready,
    output hma_pkg::t_rslt      o_out_data,
    input  wire logic           i_cfg_valid,
    output logic                o_cfg_ready,
    input  wire logic [3:0]     i_cfg_data
);
    import hma_pkg::*;

    t_cmd  cmd;
    t_stat stat;

    // register writes always taken
    assign o_cfg_ready = 1'b1;

    hma_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    hma_datapath #(
        .NUM_CONDS      (NUM_CONDS),
        .QUEUE_DEPTH    (QUEUE_DEPTH),
        .THREAD_ID_BITS (THREAD_ID_BITS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_data   (i_in_data),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_data  (i_cfg_data),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

endmodule

`default_nettype wire

>>> sv/hma_datapath.sv
// queue storage, pointers, request latch and result register
`default_nettype none

module hma_datapath #(
    parameter int NUM_CONDS      = 10,
    parameter int QUEUE_DEPTH    = 16,
    parameter int THREAD_ID_BITS = 8
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire hma_pkg::t_req  i_in_data,
    input  wire logic           i_cfg_valid,
    input  wire logic [3:0]     i_cfg_data,
    input  wire hma_pkg::t_cmd  i_cmd,
    output hma_pkg::t_stat      o_stat,
    output logic                o_out_valid,
    input  wire logic           i_out_ready,
    output hma_pkg::t_rslt      o_out_data
);
    import hma_pkg::*;

    localparam int NQ        = NUM_CONDS + 2;
    localparam int QW        = $clog2(NQ);
    localparam int SW        = $clog2(QUEUE_DEPTH);
    localparam int CW        = $clog2(QUEUE_DEPTH + 1);
    localparam int TW        = (THREAD_ID_BITS < 8) ? THREAD_ID_BITS : 8;
    localparam int MEM_DEPTH = NQ << SW;
    localparam logic [7:0]    TID_MASK  = 8'((1 << TW) - 1);
    localparam logic [QW-1:0] QN_ENTRY  = '0;
    localparam logic [QW-1:0] QN_URGENT = QW'(1);

    logic [3:0]    r_num_cond;
    t_req          r_req;
    logic          r_busy;
    logic [SW-1:0] r_head [NQ];
    logic [CW-1:0] r_cnt  [NQ];
    logic [TW-1:0] r_mem  [MEM_DEPTH];
    logic [TW-1:0] r_rdata;
    logic          r_out_valid;
    t_rslt         r_out;

    logic          is_cond_op;
    logic          bad_cond;
    logic          idx_in_range;
    logic [4:0]    cq_wide;
    logic [QW-1:0] cond_q;
    logic [QW-1:0] push_qn;
    logic [QW-1:0] pop_qn;
    logic [CW:0]   slot_sum;
    logic [SW-1:0] push_slot;
    logic [SW-1:0] pop_next;
    logic          out_free;
    t_rslt         n_out;

    // configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_num_cond <= NUM_COND_RESET;
        end else if (i_cfg_valid) begin
            r_num_cond <= i_cfg_data;
        end
    end

    // request latch, thread id cut to the kept bits
    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_req           <= i_in_data;
            r_req.thread_id <= i_in_data.thread_id & TID_MASK;
        end
    end

    // condition index check and queue number of the condition
    assign is_cond_op   = (r_req.op == OP_WAIT) || (r_req.op == OP_SIGNAL);
    assign idx_in_range = ({1'b0, r_req.cond_index} < 5'(NUM_CONDS));
    assign bad_cond     = is_cond_op &&
                          ((r_req.cond_index >= r_num_cond) || !idx_in_range);
    assign cq_wide      = {1'b0, r_req.cond_index} + 5'd2;
    assign cond_q       = idx_in_range ? QW'(cq_wide) : QN_ENTRY;

    function automatic logic [QW-1:0] qnum(input t_qsel sel, input logic [QW-1:0] cq);
        logic [QW-1:0] q;
        case (sel)
            Q_ENTRY:  q = QN_ENTRY;
            Q_URGENT: q = QN_URGENT;
            Q_COND:   q = cq;
            default:  q = QN_ENTRY;
        endcase
        return q;
    endfunction

    assign push_qn = qnum(i_cmd.push_q, cond_q);
    assign pop_qn  = qnum(i_cmd.pop_q, cond_q);

    // tail slot: head plus count, wrapped once
    assign slot_sum  = (CW+1)'(r_head[push_qn]) + (CW+1)'(r_cnt[push_qn]);
    assign push_slot = (slot_sum >= (CW+1)'(QUEUE_DEPTH))
                       ? SW'(slot_sum - (CW+1)'(QUEUE_DEPTH)) : SW'(slot_sum);
    assign pop_next  = (r_head[pop_qn] == SW'(QUEUE_DEPTH - 1))
                       ? '0 : r_head[pop_qn] + SW'(1);

    // head and count per queue
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NQ; i++) begin
                r_head[i] <= '0;
                r_cnt[i]  <= '0;
            end
        end else begin
            if (i_cmd.push) begin
                r_cnt[push_qn] <= r_cnt[push_qn] + CW'(1);
            end
            if (i_cmd.pop) begin
                r_cnt[pop_qn]  <= r_cnt[pop_qn] - CW'(1);
                r_head[pop_qn] <= pop_next;
            end
        end
    end

    // queue storage, one write and one registered read
    always_ff @(posedge i_clk) begin
        if (i_cmd.push) begin
            r_mem[{push_qn, push_slot}] <= r_req.thread_id[TW-1:0];
        end
        if (i_cmd.pop) begin
            r_rdata <= r_mem[{pop_qn, r_head[pop_qn]}];
        end
    end

    // monitor ownership flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else if (i_cmd.busy_set) begin
            r_busy <= 1'b1;
        end else if (i_cmd.busy_clr) begin
            r_busy <= 1'b0;
        end
    end

    // result register
    assign out_free = !r_out_valid || i_out_ready;

    always_comb begin
        n_out.status = i_cmd.emit_status;
        n_out.last   = i_cmd.emit_last;
        case (i_cmd.emit_src)
            E_TID:   n_out.released_thread = r_req.thread_id;
            E_MEM:   n_out.released_thread = 8'(r_rdata);
            default: n_out.released_thread = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_out <= n_out;
        end
    end

    // status toward the controller
    always_comb begin
        o_stat.op           = t_op'(r_req.op);
        o_stat.bad_cond     = bad_cond;
        o_stat.busy         = r_busy;
        o_stat.entry_empty  = (r_cnt[QN_ENTRY] == '0);
        o_stat.entry_full   = (r_cnt[QN_ENTRY] == CW'(QUEUE_DEPTH));
        o_stat.urgent_empty = (r_cnt[QN_URGENT] == '0);
        o_stat.urgent_full  = (r_cnt[QN_URGENT] == CW'(QUEUE_DEPTH));
        o_stat.cond_empty   = (r_cnt[cond_q] == '0);
        o_stat.cond_full    = (r_cnt[cond_q] == CW'(QUEUE_DEPTH));
        o_stat.out_free     = out_free;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

`default_nettype wire

>>> sv/hma_ctrl.sv
// request sequencer of the monitor lock manager
`default_nettype none

module hma_ctrl (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_in_valid,
    output logic                o_in_ready,
    input  wire hma_pkg::t_stat i_stat,
    output hma_pkg::t_cmd       o_cmd
);
    import hma_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_POP
    } t_state;

    t_state r_state;
    t_state n_state;
    t_cmd   cmd;

    // hand the monitor on: urgent head, else entry head, else free it
    function automatic void hand_on(input t_stat st, inout t_cmd c, inout t_state ns);
        if (!st.urgent_empty) begin
            c.pop      = 1'b1;
            c.pop_q    = Q_URGENT;
            c.busy_set = 1'b1;
            ns         = S_POP;
        end else if (!st.entry_empty) begin
            c.pop      = 1'b1;
            c.pop_q    = Q_ENTRY;
            c.busy_set = 1'b1;
            ns         = S_POP;
        end else begin
            c.busy_clr = 1'b1;
            ns         = S_IDLE;
        end
    endfunction

    // next state and commands
    always_comb begin
        cmd             = '0;
        cmd.push_q      = Q_ENTRY;
        cmd.pop_q       = Q_ENTRY;
        cmd.emit_src    = E_TID;
        cmd.emit_status = ST_RELEASE;
        n_state         = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    cmd.latch = 1'b1;
                    n_state   = S_EXEC;
                end
            end
            S_EXEC: begin
                if (i_stat.out_free) begin
                    n_state = S_IDLE;
                    if (i_stat.bad_cond) begin
                        cmd.emit        = 1'b1;
                        cmd.emit_src    = E_ZERO;
                        cmd.emit_status = ST_BADCOND;
                        cmd.emit_last   = 1'b1;
                    end else begin
                        case (i_stat.op)
                            OP_ENTER: begin
                                if (!i_stat.busy) begin
                                    cmd.busy_set  = 1'b1;
                                    cmd.emit      = 1'b1;
                                    cmd.emit_last = 1'b1;
                                end else if (i_stat.entry_full) begin
                                    cmd.emit        = 1'b1;
                                    cmd.emit_src    = E_ZERO;
                                    cmd.emit_status = ST_FULL;
                                    cmd.emit_last   = 1'b1;
                                end else begin
                                    cmd.push   = 1'b1;
                                    cmd.push_q = Q_ENTRY;
                                end
                            end
                            OP_LEAVE: begin
                                cmd.emit = 1'b1;
                                hand_on(i_stat, cmd, n_state);
                                cmd.emit_last = (n_state == S_IDLE);
                            end
                            OP_WAIT: begin
                                if (i_stat.cond_full) begin
                                    cmd.emit        = 1'b1;
                                    cmd.emit_src    = E_ZERO;
                                    cmd.emit_status = ST_FULL;
                                    cmd.emit_last   = 1'b1;
                                end else begin
                                    cmd.push   = 1'b1;
                                    cmd.push_q = Q_COND;
                                    hand_on(i_stat, cmd, n_state);
                                end
                            end
                            OP_SIGNAL: begin
                                if (i_stat.cond_empty) begin
                                    cmd.emit      = 1'b1;
                                    cmd.emit_last = 1'b1;
                                end else if (i_stat.urgent_full) begin
                                    cmd.emit        = 1'b1;
                                    cmd.emit_src    = E_ZERO;
                                    cmd.emit_status = ST_FULL;
                                    cmd.emit_last   = 1'b1;
                                end else begin
                                    // waiter leaves its queue, signaller parks
                                    cmd.pop    = 1'b1;
                                    cmd.pop_q  = Q_COND;
                                    cmd.push   = 1'b1;
                                    cmd.push_q = Q_URGENT;
                                    n_state    = S_POP;
                                end
                            end
                            default: n_state = S_IDLE;
                        endcase
                    end
                end
            end
            S_POP: begin
                // popped thread is in the read register now
                if (i_stat.out_free) begin
                    cmd.emit      = 1'b1;
                    cmd.emit_src  = E_MEM;
                    cmd.emit_last = 1'b1;
                    n_state       = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_ready = (r_state == S_IDLE);
    assign o_cmd      = cmd;

endmodule

`default_nettype wire

>>> sv/hma_checker.sv
// port-level checks of the monitor lock manager, bound to the top level
`default_nettype none

`include "assert_macros.svh"

module hma_checker (
    input wire logic           i_clk,
    input wire logic           i_rst_n,
    input wire logic           i_in_valid,
    input wire logic           o_in_ready,
    input wire logic           o_out_valid,
    input wire logic           i_out_ready,
    input wire hma_pkg::t_rslt o_out_data
);
    import hma_pkg::*;

    // a result waiting on the receiver holds still
    `ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && !i_out_ready,
        o_out_valid && $stable(o_out_data), "result changed while stalled")

    // error results carry no thread and end their request
    `ASSERT_IMPLY(a_err_form, i_clk, i_rst_n,
        o_out_valid && (o_out_data.status != ST_RELEASE),
        (o_out_data.released_thread == 8'd0) && o_out_data.last,
        "error result not zero or not last")

    // only the three defined status codes appear
    `ASSERT_IMPLY(a_status_code, i_clk, i_rst_n, o_out_valid,
        (o_out_data.status == ST_RELEASE) || (o_out_data.status == ST_BADCOND) ||
        (o_out_data.status == ST_FULL), "undefined status code")

    // one request at a time: no transfer in the cycle after one
    `ASSERT_NEXT(a_one_req, i_clk, i_rst_n, i_in_valid && o_in_ready, !o_in_ready,
        "request taken while another is in flight")

endmodule

bind hoare_monitor_arbiter hma_checker u_hma_checker (.*);

`default_nettype wire

>>> tb/hoare_monitor_arbiter_tb.sv
// testbench of the monitor lock manager: directed and random request traffic against a predictor
`timescale 1ns / 1ps

module hoare_monitor_arbiter_tb;
    import hma_pkg::*;

    localparam int NCOND     = 10;
    localparam int DEPTH     = 16;
    localparam int QI_ENTRY  = 0;
    localparam int QI_URGENT = 1;
    localparam int QI_COND0  = 2;
    localparam int NQ        = NCOND + 2;
    localparam int SETTLE    = 8;
    localparam int LIMIT     = 200000;
    localparam int HOLD_LEN  = 300;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_ready;
    t_req in_data = '0;
    logic out_valid;
    logic out_ready = 1'b0;
    t_rslt out_data;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [3:0] cfg_data = '0;

    // stimulus control
    t_req req_backlog[$];
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    logic hold_req = 1'b0;
    int hold_left = 0;

    // lock manager state as predicted
    logic [3:0] cond_limit = NUM_COND_RESET;
    logic mon_busy = 1'b0;
    logic [7:0] q_slot [NQ][DEPTH];
    int q_head [NQ];
    int q_cnt [NQ];
    t_rslt step_out [2];
    int step_n;
    t_rslt due_releases[$];

    // bookkeeping
    int req_queued = 0;
    int req_accepted = 0;
    int results_checked = 0;
    int err_count = 0;
    int cycles = 0;
    int cnt_full = 0;
    int cnt_badcond = 0;
    int cnt_double = 0;
    int cnt_silent = 0;

    hoare_monitor_arbiter uut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_in_valid (in_valid),
        .o_in_ready (in_ready),
        .i_in_data  (in_data),
        .o_out_valid(out_valid),
        .i_out_ready(out_ready),
        .o_out_data (out_data),
        .i_cfg_valid(cfg_valid),
        .o_cfg_ready(cfg_ready),
        .i_cfg_data (cfg_data)
    );

    // 8 ns clock
    always begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    task automatic flag_error(input string msg);
        $display("ERROR @%0t: %s", $time, msg);
        err_count++;
    endtask

    // queue helpers of the predictor
    function automatic void park_thread(input int q, input logic [7:0] tid);
        q_slot[q][(q_head[q] + q_cnt[q]) % DEPTH] = tid;
        q_cnt[q] = q_cnt[q] + 1;
    endfunction

    function automatic logic [7:0] take_thread(input int q);
        logic [7:0] v;
        v = q_slot[q][q_head[q]];
        q_head[q] = (q_head[q] + 1) % DEPTH;
        q_cnt[q] = q_cnt[q] - 1;
        return v;
    endfunction

    function automatic void emit_release(input logic [7:0] tid, input t_status st);
        step_out[step_n].released_thread = tid;
        step_out[step_n].status = st;
        step_out[step_n].last = 1'b0;
        step_n++;
    endfunction

    // urgent head first, then entry head, else the monitor goes free
    function automatic void pass_monitor();
        if (q_cnt[QI_URGENT] != 0) begin
            mon_busy = 1'b1;
            emit_release(take_thread(QI_URGENT), ST_RELEASE);
        end else if (q_cnt[QI_ENTRY] != 0) begin
            mon_busy = 1'b1;
            emit_release(take_thread(QI_ENTRY), ST_RELEASE);
        end else begin
            mon_busy = 1'b0;
        end
    endfunction

    // releases caused by one accepted request
    function automatic void arbitrate_request(input t_req req);
        int lim;
        int cq;
        lim = (cond_limit > NCOND) ? NCOND : cond_limit;
        cq = QI_COND0 + req.cond_index;
        step_n = 0;
        if ((req.op == OP_WAIT || req.op == OP_SIGNAL) && req.cond_index >= lim) begin
            emit_release(8'd0, ST_BADCOND);
        end else if (req.op == OP_ENTER) begin
            if (!mon_busy) begin
                mon_busy = 1'b1;
                emit_release(req.thread_id, ST_RELEASE);
            end else if (q_cnt[QI_ENTRY] >= DEPTH) begin
                emit_release(8'd0, ST_FULL);
            end else begin
                park_thread(QI_ENTRY, req.thread_id);
            end
        end else if (req.op == OP_LEAVE) begin
            emit_release(req.thread_id, ST_RELEASE);
            pass_monitor();
        end else if (req.op == OP_WAIT) begin
            if (q_cnt[cq] >= DEPTH) begin
                emit_release(8'd0, ST_FULL);
            end else begin
                park_thread(cq, req.thread_id);
                pass_monitor();
            end
        end else begin
            if (q_cnt[cq] == 0) begin
                emit_release(req.thread_id, ST_RELEASE);
            end else if (q_cnt[QI_URGENT] >= DEPTH) begin
                emit_release(8'd0, ST_FULL);
            end else begin
                emit_release(take_thread(cq), ST_RELEASE);
                park_thread(QI_URGENT, req.thread_id);
            end
        end
        if (step_n > 0) begin
            step_out[step_n - 1].last = 1'b1;
        end
        for (int k = 0; k < step_n; k++) begin
            due_releases.push_back(step_out[k]);
            if (step_out[k].status == ST_FULL) cnt_full++;
            if (step_out[k].status == ST_BADCOND) cnt_badcond++;
        end
        if (step_n == 2) cnt_double++;
        if (step_n == 0) cnt_silent++;
    endfunction

    // request driver
    always @(posedge clk) begin
        if (!rst_n) begin
            in_valid <= 1'b0;
        end else begin
            if (in_valid && in_ready) begin
                arbitrate_request(in_data);
                req_accepted++;
            end
            if (!in_valid || in_ready) begin
                if (req_backlog.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    in_valid <= 1'b1;
                    in_data <= req_backlog.pop_front();
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // long receiver hold-off
    always @(posedge clk) begin
        if (!rst_n) begin
            hold_left <= 0;
        end else if (hold_req) begin
            hold_left <= HOLD_LEN;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end
    end

    // result monitor and checker
    always @(posedge clk) begin : result_check
        t_rslt want;
        if (!rst_n) begin
            out_ready <= 1'b0;
        end else begin
            if (out_valid && out_ready) begin
                results_checked++;
                if (due_releases.size() == 0) begin
                    flag_error($sformatf("unexpected result thread %0h status %0d last %0d",
                        out_data.released_thread, out_data.status, out_data.last));
                end else begin
                    want = due_releases.pop_front();
                    if (out_data.released_thread !== want.released_thread ||
                        out_data.status !== want.status || out_data.last !== want.last) begin
                        flag_error($sformatf(
                            "result thread %0h status %0d last %0d, want %0h %0d %0d",
                            out_data.released_thread, out_data.status, out_data.last,
                            want.released_thread, want.status, want.last));
                    end
                end
            end
            out_ready <= (hold_left == 0) && ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // run limit
    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                cycles, due_releases.size());
            $display("CHECKS FAILED");
            $finish;
        end
    end

    task automatic queue_req(input t_op op, input logic [7:0] tid, input logic [3:0] cv);
        t_req r;
        r.op = op;
        r.thread_id = tid;
        r.cond_index = cv;
        req_backlog.push_back(r);
        req_queued++;
    endtask

    // mostly a valid index for the current setting, sometimes anything
    function automatic logic [3:0] pick_cond();
        int lim;
        lim = (cond_limit > NCOND) ? NCOND : cond_limit;
        if (lim == 0 || $urandom_range(9) == 0) begin
            return 4'($urandom_range(15));
        end
        return 4'($urandom_range(lim - 1));
    endfunction

    function automatic logic [7:0] any_tid();
        return 8'($urandom_range(255));
    endfunction

    // handoffs through the entry, urgent and condition queues, bad indices, ignored index fields
    task automatic queue_directed();
        queue_req(OP_ENTER,  8'h00, 4'd0);
        queue_req(OP_ENTER,  8'hFF, 4'd0);
        queue_req(OP_ENTER,  8'hA5, 4'd3);
        queue_req(OP_SIGNAL, 8'h00, 4'd0);
        queue_req(OP_WAIT,   8'h00, 4'd9);
        queue_req(OP_SIGNAL, 8'hFF, 4'd9);
        queue_req(OP_LEAVE,  8'h00, 4'd15);
        queue_req(OP_WAIT,   8'hFF, 4'd0);
        queue_req(OP_WAIT,   8'hA5, 4'd10);
        queue_req(OP_SIGNAL, 8'hA5, 4'd15);
        queue_req(OP_LEAVE,  8'hA5, 4'd0);
        queue_req(OP_WAIT,   8'h3C, 4'd4);
        queue_req(OP_LEAVE,  8'h81, 4'd7);
        queue_req(OP_ENTER,  8'h7E, 4'd12);
        queue_req(OP_SIGNAL, 8'h7E, 4'd0);
        queue_req(OP_SIGNAL, 8'hFF, 4'd4);
        queue_req(OP_LEAVE,  8'h3C, 4'd0);
        queue_req(OP_LEAVE,  8'h7E, 4'd0);
        queue_req(OP_LEAVE,  8'hFF, 4'd0);
        queue_req(OP_WAIT,   8'h5A, 4'd11);
        queue_req(OP_SIGNAL, 8'h5A, 4'd8);
    endtask

    // bursts that fill and drain the queues, plus mixed traffic and noise
    task automatic queue_random(input int count);
        int stop;
        int mode;
        int len;
        logic [3:0] c0;
        logic [3:0] c1;
        stop = req_queued + count;
        while (req_queued < stop) begin
            mode = $urandom_range(6);
            c0 = pick_cond();
            c1 = pick_cond();
            case (mode)
                0, 1: begin
                    len = $urandom_range(10, 25);
                    for (int k = 0; k < len; k++)
                        queue_req(t_op'($urandom_range(3)), any_tid(), pick_cond());
                end
                2: begin
                    // entry queue toward full
                    len = $urandom_range(12, 22);
                    for (int k = 0; k < len; k++) queue_req(OP_ENTER, any_tid(), pick_cond());
                    for (int k = 0; k < 3; k++) queue_req(OP_LEAVE, any_tid(), pick_cond());
                end
                3: begin
                    // one condition toward full
                    len = $urandom_range(8, 18);
                    for (int k = 0; k < len; k++) begin
                        if ($urandom_range(4) == 0) queue_req(OP_ENTER, any_tid(), c1);
                        else queue_req(OP_WAIT, any_tid(), c0);
                    end
                end
                4: begin
                    // waiters on two conditions, then signals until urgent fills
                    len = $urandom_range(14, 18);
                    for (int k = 0; k < len; k++) queue_req(OP_WAIT, any_tid(), c0);
                    len = $urandom_range(14, 18);
                    for (int k = 0; k < len; k++) queue_req(OP_WAIT, any_tid(), c1);
                    len = $urandom_range(16, 24);
                    for (int k = 0; k < len; k++)
                        queue_req(OP_SIGNAL, any_tid(), k[0] ? c1 : c0);
                end
                5: begin
                    // drain
                    len = $urandom_range(8, 20);
                    for (int k = 0; k < len; k++) begin
                        if ($urandom_range(3) == 0) queue_req(OP_SIGNAL, any_tid(), c0);
                        else queue_req(OP_LEAVE, any_tid(), pick_cond());
                    end
                end
                default: begin
                    len = $urandom_range(5, 15);
                    for (int k = 0; k < len; k++)
                        queue_req(t_op'($urandom_range(3)), any_tid(), 4'($urandom_range(15)));
                end
            endcase
        end
    endtask

    // all requests taken and all results seen, then let the sequencer settle
    task automatic wait_drained();
        do @(posedge clk);
        while (req_backlog.size() != 0 || in_valid || due_releases.size() != 0);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic set_cond_count(input logic [3:0] v);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data <= v;
        do @(posedge clk);
        while (!cfg_ready);
        cond_limit = v;
        cfg_valid <= 1'b0;
    endtask

    task automatic set_idling(input int send, input int recv);
        send_idle_pct = send;
        recv_stall_pct = recv;
    endtask

    // phase sequence
    initial begin
        for (int q = 0; q < NQ; q++) begin
            q_head[q] = 0;
            q_cnt[q] = 0;
        end
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset setting, no idling
        set_idling(0, 0);
        queue_directed();
        queue_random(150);
        wait_drained();

        // setting above the condition count, idle sender
        set_cond_count(4'd15);
        set_idling(51, 0);
        queue_random(150);
        wait_drained();

        // single condition, stalling receiver
        set_cond_count(4'd1);
        set_idling(0, 51);
        queue_random(120);
        wait_drained();

        // no condition accepted
        set_cond_count(4'd0);
        set_idling(28, 28);
        queue_random(40);
        wait_drained();

        // long hold-off while requests keep coming
        set_cond_count(4'd6);
        queue_random(120);
        @(posedge clk);
        hold_req <= 1'b1;
        @(posedge clk);
        hold_req <= 1'b0;
        wait_drained();

        // back to full count, no idling
        set_cond_count(4'd10);
        set_idling(0, 0);
        queue_random(120);
        wait_drained();

        $display("covered %0d requests in six phases, %0d results checked, %0d silent",
            req_accepted, results_checked, cnt_silent);
        $display("seen %0d queue-full drops, %0d bad indices, %0d double releases",
            cnt_full, cnt_badcond, cnt_double);
        if (err_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
